@@ sv/krst_pkg.sv @@
// Shared constants, types and sequencer states of the keyed running statistics table.
`default_nettype none

package krst_pkg;

  localparam int AGENT_SLOTS   = 64;
  localparam int MAX_TYPE_CODE = 44;
  localparam int TYPE_STRIDE   = MAX_TYPE_CODE + 1;
  localparam int TABLE_SIZE    = AGENT_SLOTS * TYPE_STRIDE;
  localparam int IDX_W         = $clog2(TABLE_SIZE);

  localparam int AGENT_W = 6;
  localparam int TYPE_W  = 8;
  localparam int DATA_W  = 32;

  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_BAD_TYPE = 1'b1;

  typedef struct packed {
    logic        [DATA_W-1:0] cnt;
    logic signed [DATA_W-1:0] min;
    logic signed [DATA_W-1:0] max;
    logic signed [DATA_W-1:0] mean;
  } krst_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_SIGN,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } krst_state_t;

endpackage

`default_nettype wire

@@ sv/keyed_running_stats_table_top.sv @@
// Top level of the keyed running statistics table: sequencer, entry memories and divider.
`default_nettype none

// Keeps count, minimum, maximum and truncated mean for each (agent slot, type code) pair
// in a 2880-entry table. After reset the block sweeps the present marks clear, one entry a
// cycle, and holds in_stall high meanwhile. Items are then handled one at a time: a rejected
// type code goes straight to the result, a drain or the first sample of an entry passes
// through read and update, and a sample on a present entry also passes through the shared
// radix-2 divider, which retires one quotient bit a cycle to form the new mean. A finished
// result waits in the output register while the next item is already accepted.
module keyed_running_stats_table_top
  import krst_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst_n,

  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         in_action,
  input  wire         [AGENT_W-1:0]   in_agent_index,
  input  wire         [TYPE_W-1:0]    in_data_type,
  input  wire  signed [DATA_W-1:0]    in_sample_value,

  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        out_status,
  output logic                        out_entry_found,
  output logic        [DATA_W-1:0]    out_sample_count,
  output logic signed [DATA_W-1:0]    out_minimum,
  output logic signed [DATA_W-1:0]    out_maximum,
  output logic signed [DATA_W-1:0]    out_mean
);

  // entry memories
  logic        pres_mem [TABLE_SIZE];
  krst_entry_t data_mem [TABLE_SIZE];

  krst_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;

  logic               act_r, act_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic               skip_r, skip_nxt;

  logic               rd_pres_r;
  krst_entry_t        rd_ent_r;

  logic               res_status_r, res_status_nxt;
  logic               res_found_r, res_found_nxt;
  krst_entry_t        res_r, res_nxt;

  logic [2*DATA_W-1:0] prod_r, prod_nxt;
  logic                neg_r, neg_nxt;
  logic [DATA_W:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W:0]     dvs_r, dvs_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_found_r, out_found_nxt;
  krst_entry_t         out_ent_r, out_ent_nxt;

  logic                finish;
  logic [DATA_W-1:0]   mean_abs;
  logic [DATA_W-1:0]   val_abs;
  logic [2*DATA_W-1:0] vm;
  logic [2*DATA_W-1:0] mag;
  logic                pneg;
  logic                vneg;
  logic [DATA_W+1:0]   trial;

  assign mean_abs = rd_ent_r.mean[DATA_W-1] ? (~rd_ent_r.mean + 1'b1) : rd_ent_r.mean;
  assign val_abs  = val_r[DATA_W-1] ? (~val_r + 1'b1) : val_r;
  assign vm       = {{DATA_W{1'b0}}, val_abs};
  assign pneg     = rd_ent_r.mean[DATA_W-1] && (prod_r != '0);
  assign vneg     = val_r[DATA_W-1];
  assign trial    = {rem_r, quo_r[DATA_W-1]} - {1'b0, dvs_r};

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    act_nxt        = act_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    skip_nxt       = skip_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_nxt        = res_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_ent_nxt    = out_ent_r;
    finish         = 1'b0;
    mag            = '0;
    in_stall       = (state_r != ST_IDLE);

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(TABLE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          act_nxt        = in_action;
          val_nxt        = in_sample_value;
          idx_nxt        = IDX_W'(in_agent_index) * IDX_W'(TYPE_STRIDE)
                           + IDX_W'(in_data_type);
          res_status_nxt = STAT_OK;
          res_found_nxt  = 1'b0;
          res_nxt        = '0;
          skip_nxt       = 1'b1;
          if (in_data_type > TYPE_W'(MAX_TYPE_CODE)) begin
            res_status_nxt = STAT_BAD_TYPE;
            state_nxt      = ST_DONE;
          end else if (32'(in_agent_index) >= 32'(AGENT_SLOTS)) begin
            state_nxt = ST_DONE;
          end else begin
            skip_nxt  = 1'b0;
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        state_nxt = ST_CALC;
      end

      ST_CALC: begin
        res_found_nxt = rd_pres_r;
        state_nxt     = ST_DONE;
        if (act_r == ACT_DRAIN) begin
          res_nxt = rd_pres_r ? rd_ent_r : '0;
        end else if (!rd_pres_r) begin
          res_nxt.cnt  = DATA_W'(1);
          res_nxt.min  = val_r;
          res_nxt.max  = val_r;
          res_nxt.mean = val_r;
        end else begin
          res_nxt = rd_ent_r;
          if (rd_ent_r.max < val_r) begin
            res_nxt.max = val_r;
          end else if (rd_ent_r.min > val_r) begin
            res_nxt.min = val_r;
          end
          if (rd_ent_r.cnt != '1) begin
            res_nxt.cnt = rd_ent_r.cnt + 1'b1;
          end
          prod_nxt  = {{DATA_W{1'b0}}, rd_ent_r.cnt} * {{DATA_W{1'b0}}, mean_abs};
          state_nxt = ST_SIGN;
        end
      end

      ST_SIGN: begin
        // combine count*|mean| and |value| as sign and magnitude
        if (pneg == vneg) begin
          mag     = prod_r + vm;
          neg_nxt = pneg;
        end else if (prod_r >= vm) begin
          mag     = prod_r - vm;
          neg_nxt = pneg;
        end else begin
          mag     = vm - prod_r;
          neg_nxt = vneg;
        end
        // quotient stays within 32 bits, so the upper half is already below the divisor
        rem_nxt   = {1'b0, mag[2*DATA_W-1:DATA_W]};
        quo_nxt   = mag[DATA_W-1:0];
        dvs_nxt   = {1'b0, rd_ent_r.cnt} + 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (!trial[DATA_W+1]) begin
          rem_nxt = trial[DATA_W:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIX;
        end
      end

      ST_FIX: begin
        res_nxt.mean = neg_r ? (~quo_r + 1'b1) : quo_r;
        state_nxt    = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          finish         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_ent_nxt    = res_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    skip_r       <= skip_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_r        <= res_nxt;
    prod_r       <= prod_nxt;
    neg_r        <= neg_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    step_r       <= step_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_ent_r    <= out_ent_nxt;
  end

  // present marks: clearing sweep, then one write per finished item that read the table
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      pres_mem[clr_r] <= 1'b0;
    end else if (finish && !skip_r) begin
      pres_mem[idx_r] <= (act_r == ACT_ADD) || rd_pres_r;
    end
    if (state_r == ST_READ) begin
      rd_pres_r <= pres_mem[idx_r];
    end
  end

  // statistics words: a drain leaves zeros behind
  always_ff @(posedge clk) begin
    if (finish && !skip_r) begin
      data_mem[idx_r] <= (act_r == ACT_DRAIN) ? '0 : res_r;
    end
    if (state_r == ST_READ) begin
      rd_ent_r <= data_mem[idx_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_found  = out_found_r;
  assign out_sample_count = out_ent_r.cnt;
  assign out_minimum      = out_ent_r.min;
  assign out_maximum      = out_ent_r.max;
  assign out_mean         = out_ent_r.mean;

endmodule

`default_nettype wire
